// ----- hw/rtl/kvrp_pkg.sv -----
// ----------------------------------------------------------------------------
// kvrp_pkg
// Shared types and constants of the cache text reply parser.
// ----------------------------------------------------------------------------
package kvrp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [14:0] {
    PH_START   = 15'h0001,
    PH_LEAD    = 15'h0002,
    PH_SKIP    = 15'h0004,
    PH_KEY     = 15'h0008,
    PH_FLAGS   = 15'h0010,
    PH_LENGTH  = 15'h0020,
    PH_CASLF   = 15'h0040,
    PH_CAS     = 15'h0080,
    PH_LF      = 15'h0100,
    PH_DATA    = 15'h0200,
    PH_TRAILER = 15'h0400,
    PH_TEXT    = 15'h0800,
    PH_ERRLINE = 15'h1000,
    PH_NUMBER  = 15'h2000,
    PH_NUMTAIL = 15'h4000
  } phase_t;

  // Keyword kinds.
  localparam logic [3:0] KW_VALUE      = 4'd0;
  localparam logic [3:0] KW_VERSION    = 4'd1;
  localparam logic [3:0] KW_END        = 4'd2;
  localparam logic [3:0] KW_EXISTS     = 4'd3;
  localparam logic [3:0] KW_OK         = 4'd4;
  localparam logic [3:0] KW_STORED     = 4'd5;
  localparam logic [3:0] KW_STAT       = 4'd6;
  localparam logic [3:0] KW_DELETED    = 4'd7;
  localparam logic [3:0] KW_MISS       = 4'd8;
  localparam logic [3:0] KW_NOSTORE    = 4'd9;
  localparam logic [3:0] KW_TOUCHED    = 4'd10;
  // Error line kinds, kept in the keyword kind register.
  localparam logic [3:0] KW_ERR_CLIENT = 4'd1;
  localparam logic [3:0] KW_ERR_SERVER = 4'd2;

  // Event codes.
  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_KEY     = 4'd1;
  localparam logic [3:0] EV_HEADER  = 4'd2;
  localparam logic [3:0] EV_DATA    = 4'd3;
  localparam logic [3:0] EV_VALUE   = 4'd4;
  localparam logic [3:0] EV_STATUS  = 4'd5;
  localparam logic [3:0] EV_END     = 4'd6;
  localparam logic [3:0] EV_NUMBER  = 4'd7;
  localparam logic [3:0] EV_VERSION = 4'd8;
  localparam logic [3:0] EV_STAT    = 4'd9;
  localparam logic [3:0] EV_LINE    = 4'd10;
  localparam logic [3:0] EV_ERROR   = 4'd11;

  // Error kinds.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CLIENT = 2'd1;
  localparam logic [1:0] ERR_SERVER = 2'd2;
  localparam logic [1:0] ERR_LEAD   = 2'd3;

  // One result word.
  typedef struct packed {
    logic [63:0] number_value;
    logic [63:0] cas_value;
    logic [31:0] value_length;
    logic [31:0] item_flags;
    logic [1:0]  error_kind;
    logic [2:0]  status_code;
    logic [7:0]  data_byte;
    logic [3:0]  event_res;
  } result_t;

  // Full keyword length in bytes.
  function automatic logic [3:0] kw_len(input logic [3:0] kind);
    case (kind)
      KW_VALUE:      kw_len = 4'd6;
      KW_VERSION:    kw_len = 4'd8;
      KW_END:        kw_len = 4'd5;
      KW_EXISTS:     kw_len = 4'd8;
      KW_OK:         kw_len = 4'd4;
      KW_STORED:     kw_len = 4'd8;
      KW_STAT:       kw_len = 4'd5;
      KW_DELETED:    kw_len = 4'd9;
      KW_MISS:       kw_len = 4'd11;
      KW_NOSTORE:    kw_len = 4'd12;
      KW_TOUCHED:    kw_len = 4'd9;
      default:       kw_len = 4'd0;
    endcase
  endfunction

  // Status code reported for a status keyword.
  function automatic logic [2:0] kw_status(input logic [3:0] kind);
    case (kind)
      KW_EXISTS:     kw_status = 3'd2;
      KW_OK:         kw_status = 3'd6;
      KW_DELETED:    kw_status = 3'd3;
      KW_MISS:       kw_status = 3'd4;
      KW_NOSTORE:    kw_status = 3'd1;
      KW_TOUCHED:    kw_status = 3'd5;
      default:       kw_status = 3'd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/kv_cache_text_reply_parser_core.sv -----
// ----------------------------------------------------------------------------
// kv_cache_text_reply_parser_core
// Text reply parser for a key-value cache: one reply byte in, one result out.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word
//  s_axis  | in        | rx_byte
//  m_axis  | out       | result fields (see m_axis_tdata)
//
// One byte is taken per cycle unless the output stalls; each gives one result in
// the next cycle from the output register. The byte decode and state update sit
// between the input handshake and that register. rst clears the parse state to
// line start. A stalled output holds its word; a new byte enters whenever the
// output register is empty or being read in the same cycle.
module kv_cache_text_reply_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] event_res, [11:4] data_byte, [14:12] status_code, [46:15] item_flags,
  // [78:47] value_length, [142:79] cas_value, [206:143] number_value,
  // [208:207] error_kind, [215:209] zero
  output logic [215:0] m_axis_tdata
);
  import kvrp_pkg::*;

  result_t res;
  result_t out_word;
  logic    take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  kvrp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .en      (take),
    .rx_byte (s_axis_tdata),
    .res     (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_word <= res;
  end

  assign m_axis_tdata = {7'd0, out_word.error_kind, out_word.number_value,
                         out_word.cas_value, out_word.value_length,
                         out_word.item_flags, out_word.status_code,
                         out_word.data_byte, out_word.event_res};

endmodule

// ----- hw/rtl/kvrp_step.sv -----
// ----------------------------------------------------------------------------
// kvrp_step
// Parser state and the per-byte decode that forms one result word.
// ----------------------------------------------------------------------------
module kvrp_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  output kvrp_pkg::result_t res
);
  import kvrp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  kind, kind_next;
  logic [3:0]  left, left_next;
  logic [7:0]  lead0, lead0_next;
  logic [63:0] accum, accum_next;
  logic [31:0] flags, flags_next;
  logic [31:0] length, length_next;
  logic [63:0] cas, cas_next;
  logic [32:0] bytes_left, bytes_left_next;

  logic        dig;
  logic [63:0] acc_dig;
  logic [63:0] digit;
  logic        hdr;
  logic [3:0]  left_dec;
  logic [32:0] bl_dec;

  assign dig     = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign digit   = {60'd0, rx_byte[3:0]};
  assign acc_dig = (accum << 3) + (accum << 1) + digit;
  assign left_dec = (left != 4'd0) ? left - 4'd1 : left;
  assign bl_dec   = (bytes_left != 33'd0) ? bytes_left - 33'd1 : bytes_left;

  // Next-state and result decode.
  always_comb begin
    phase_next = phase;
    kind_next = kind;
    left_next = left;
    lead0_next = lead0;
    accum_next = accum;
    flags_next = flags;
    length_next = length;
    cas_next = cas;
    bytes_left_next = bytes_left;
    hdr = 1'b0;
    res = '0;
    case (phase)
      PH_START: begin
        lead0_next = rx_byte;
        left_next = 4'd1;
        if (rx_byte == "V" || rx_byte == "E" || rx_byte == "S" || rx_byte == "N") begin
          phase_next = PH_LEAD;
        end else if (rx_byte == "O") begin
          kind_next = KW_OK; left_next = kw_len(KW_OK) - 4'd1; phase_next = PH_SKIP;
        end else if (rx_byte == "D") begin
          kind_next = KW_DELETED; left_next = kw_len(KW_DELETED) - 4'd1;
          phase_next = PH_SKIP;
        end else if (rx_byte == "T") begin
          kind_next = KW_TOUCHED; left_next = kw_len(KW_TOUCHED) - 4'd1;
          phase_next = PH_SKIP;
        end else if (rx_byte == "C") begin
          kind_next = KW_ERR_CLIENT; phase_next = PH_ERRLINE;
        end else if (dig) begin
          accum_next = digit; phase_next = PH_NUMBER;
        end else begin
          res.event_res = EV_ERROR; res.error_kind = ERR_LEAD;
        end
      end
      PH_LEAD: begin
        if (left == 4'd0 || left > 4'd4) begin
          phase_next = PH_START;
        end else begin
          left_next = left + 4'd1;
          case (lead0)
            "V": begin
              if (rx_byte == "A") begin
                kind_next = KW_VALUE; left_next = kw_len(KW_VALUE) - 4'd2;
                phase_next = PH_SKIP;
              end else if (rx_byte == "E") begin
                kind_next = KW_VERSION; left_next = kw_len(KW_VERSION) - 4'd2;
                phase_next = PH_SKIP;
              end else begin
                res.event_res = EV_ERROR; res.error_kind = ERR_LEAD;
                phase_next = PH_START;
              end
            end
            "E": begin
              if (rx_byte == "R") begin
                kind_next = KW_ERR_CLIENT; phase_next = PH_ERRLINE;
              end else if (rx_byte == "N") begin
                kind_next = KW_END; left_next = kw_len(KW_END) - 4'd2;
                phase_next = PH_SKIP;
              end else if (rx_byte == "X") begin
                kind_next = KW_EXISTS; left_next = kw_len(KW_EXISTS) - 4'd2;
                phase_next = PH_SKIP;
              end else begin
                res.event_res = EV_ERROR; res.error_kind = ERR_LEAD;
                phase_next = PH_START;
              end
            end
            "S": begin
              if (left == 4'd1) begin
                if (rx_byte == "T") begin
                  phase_next = PH_LEAD;
                end else if (rx_byte == 8'h0A) begin
                  res.event_res = EV_ERROR; res.error_kind = ERR_SERVER;
                  phase_next = PH_START;
                end else begin
                  kind_next = KW_ERR_SERVER; phase_next = PH_ERRLINE;
                end
              end else if (rx_byte == "O") begin
                kind_next = KW_STORED; left_next = kw_len(KW_STORED) - 4'd3;
                phase_next = PH_SKIP;
              end else begin
                kind_next = KW_STAT; left_next = kw_len(KW_STAT) - 4'd3;
                phase_next = PH_SKIP;
              end
            end
            "N": begin
              if (left == 4'd4) begin
                if (rx_byte == "F") begin
                  kind_next = KW_MISS; left_next = kw_len(KW_MISS) - 4'd5;
                  phase_next = PH_SKIP;
                end else if (rx_byte == "S") begin
                  kind_next = KW_NOSTORE;
                  left_next = kw_len(KW_NOSTORE) - 4'd5;
                  phase_next = PH_SKIP;
                end else begin
                  res.event_res = EV_ERROR; res.error_kind = ERR_LEAD;
                  phase_next = PH_START;
                end
              end
            end
            default: phase_next = PH_START;
          endcase
        end
      end
      PH_SKIP: begin
        left_next = left_dec;
        if (left_dec == 4'd0) begin
          phase_next = PH_START;
          if (kind > KW_TOUCHED) begin
            phase_next = PH_START;
          end else if (kind == KW_VALUE) begin
            phase_next = PH_KEY;
          end else if (kind == KW_VERSION || kind == KW_STAT) begin
            phase_next = PH_TEXT;
          end else if (kind == KW_END) begin
            res.event_res = EV_END;
          end else begin
            res.event_res = EV_STATUS; res.status_code = kw_status(kind);
          end
        end
      end
      PH_KEY: begin
        if (rx_byte == " ") begin
          accum_next = '0; phase_next = PH_FLAGS;
        end else begin
          res.event_res = EV_KEY; res.data_byte = rx_byte;
        end
      end
      PH_FLAGS: begin
        if (dig) accum_next = acc_dig;
        else begin
          flags_next = accum[31:0]; accum_next = '0; phase_next = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (dig) accum_next = acc_dig;
        else begin
          length_next = accum[31:0]; accum_next = '0; phase_next = PH_CASLF;
        end
      end
      PH_CASLF: begin
        if (rx_byte == 8'h0A) begin
          cas_next = '0; hdr = 1'b1;
        end else if (dig) begin
          accum_next = digit; phase_next = PH_CAS;
        end else begin
          cas_next = '0; phase_next = PH_LF;
        end
      end
      PH_CAS: begin
        if (dig) accum_next = acc_dig;
        else begin
          cas_next = accum; phase_next = PH_LF;
        end
      end
      PH_LF: hdr = 1'b1;
      PH_DATA: begin
        res.event_res = EV_DATA; res.data_byte = rx_byte;
        bytes_left_next = bl_dec;
        if (bl_dec == 33'd0) begin
          left_next = 4'd2; phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        left_next = left_dec;
        if (left_dec == 4'd0) begin
          res.event_res = EV_VALUE; phase_next = PH_START;
        end
      end
      PH_TEXT: begin
        if (rx_byte == 8'h0A) begin
          res.event_res = EV_LINE; phase_next = PH_START;
        end else begin
          res.event_res = (kind == KW_VERSION) ? EV_VERSION : EV_STAT;
          res.data_byte = rx_byte;
        end
      end
      PH_ERRLINE: begin
        if (rx_byte == 8'h0A) begin
          res.event_res = EV_ERROR;
          res.error_kind = (kind == KW_ERR_SERVER) ? ERR_SERVER : ERR_CLIENT;
          phase_next = PH_START;
        end
      end
      PH_NUMBER: begin
        if (dig) accum_next = acc_dig;
        else begin
          res.event_res = EV_NUMBER; res.number_value = accum;
          phase_next = PH_NUMTAIL;
        end
      end
      PH_NUMTAIL: begin
        if (rx_byte == 8'h0A) phase_next = PH_START;
      end
      default: phase_next = PH_START;
    endcase

    // Header complete: arm the data block or go straight to the trailer.
    if (hdr) begin
      res.event_res = EV_HEADER;
      bytes_left_next = {1'b0, length};
      if (length == 32'd0) begin
        left_next = 4'd2; phase_next = PH_TRAILER;
      end else begin
        phase_next = PH_DATA;
      end
    end

    // Value events report the header as updated by this byte.
    if (res.event_res == EV_HEADER || res.event_res == EV_DATA ||
        res.event_res == EV_VALUE) begin
      res.item_flags = flags_next;
      res.value_length = length_next;
      res.cas_value = cas_next;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      kind <= '0;
      left <= '0;
      lead0 <= '0;
      accum <= '0;
      flags <= '0;
      length <= '0;
      cas <= '0;
      bytes_left <= '0;
    end else if (en) begin
      phase <= phase_next;
      kind <= kind_next;
      left <= left_next;
      lead0 <= lead0_next;
      accum <= accum_next;
      flags <= flags_next;
      length <= length_next;
      cas <= cas_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule
